// ===== sv/vda_pkg.sv =====
// ----------------------------------------------------------------------------
// vda_pkg
// shared types and constants for the vector distance accumulator
// ----------------------------------------------------------------------------
package vda_pkg;

    // running sum, fraction and result widths
    localparam int SUM_W      = 45;
    localparam int FRAC_W     = 8;
    localparam int DIST_W     = 30;

    // square root steps: one result bit per step over sum << (2 * FRAC_W)
    localparam int SQRT_STEPS = (SUM_W + 2 * FRAC_W + 1) / 2;
    localparam int SQRT_KW    = $clog2(SQRT_STEPS);

    // configuration port
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register indexes (word address bits of paddr)
    localparam logic [0:0] REG_METRIC_MODE = 1'b0;

    // metric codes
    localparam logic MODE_EUCLID    = 1'b0;
    localparam logic MODE_MANHATTAN = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CHK  = 5'b00100,
        S_SQRT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // status flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic count_full;
        logic mode_manh;
        logic last;
        logic mplier_zero;
        logic sum_over;
        logic sat;
        logic k_zero;
        logic out_free;
    } t_seq_stat;

endpackage

// ===== sv/vda_addsub.sv =====
// ----------------------------------------------------------------------------
// vda_addsub
// shared adder / subtractor used by the multiply and square root steps
// ----------------------------------------------------------------------------
module vda_addsub
    import vda_pkg::*;
#(
    parameter int W = 62
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_res,
    output logic         o_carry
);

    logic [W:0] w_sum;
    logic [W-1:0] w_b;

    // a + b, or a - b with carry high when a >= b
    assign w_b     = i_sub ? ~i_b : i_b;
    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, i_sub};
    assign o_res   = w_sum[W-1:0];
    assign o_carry = w_sum[W];

endmodule

// ===== sv/vda_seq.sv =====
// ----------------------------------------------------------------------------
// vda_seq
// sequencer stepping one word through multiply, check and square root
// ----------------------------------------------------------------------------
module vda_seq
    import vda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seq_stat i_stat,
    output t_state    o_state
);

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.accept) begin
                    if (i_stat.count_full) begin
                        n_state = i_stat.last ? S_DONE : S_IDLE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (i_stat.mplier_zero) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.sat || i_stat.sum_over || i_stat.mode_manh) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.k_zero) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== sv/vector_distance_accumulator.sv =====
// ----------------------------------------------------------------------------
// vector_distance_accumulator
// accumulates squared or absolute element differences, gives one distance
// per vector (euclidean as 22.8 fixed-point square root, or manhattan sum)
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_elem_a, i_elem_b, i_last_elem
//  output    out        o_out_valid / i_out_ready o_distance, o_overflow
//  config    in         psel / penable / pready   paddr, pwdata, pwrite, prdata
//
//  one shared adder does the multiply and square root arithmetic; each word is
//  multiplied by shift and add over the bits of |a - b| (manhattan adds it once)
//  and checked; a last word then gives a result, a euclidean one that has not
//  saturated running the square root first; a word past MAX_LEN is dropped;
//  o_in_ready is low while the sequencer is not idle; the result sits in an
//  output register, so a stalled output only holds the result state;
//  synchronous active-low reset clears sum, count and flags
// ----------------------------------------------------------------------------
module vector_distance_accumulator
    import vda_pkg::*;
#(
    parameter int MAX_LEN    = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last_elem,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DIST_W-1:0]     o_distance,
    output logic                  o_overflow,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int EW   = ELEM_WIDTH;
    localparam int PW   = (SUM_W + 2 * FRAC_W > 2 * EW) ? SUM_W + 2 * FRAC_W : 2 * EW;
    localparam int UW   = PW + 1;
    localparam int CW   = $clog2(MAX_LEN + 1);

    // configuration register
    logic r_mode;

    // per-word and accumulator state
    logic              r_item_mode;
    logic              r_last;
    logic [UW-1:0]     r_acc;
    logic [UW-1:0]     r_mcand;
    logic [EW-1:0]     r_mplier;
    logic [SQRT_KW-1:0] r_k;
    logic [CW-1:0]     r_count;
    logic              r_sat;

    // output register
    logic              r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic              r_ovf;

    t_state    w_state;
    t_seq_stat w_stat;

    logic              w_accept;
    logic              w_count_full;
    logic signed [EW:0] w_diff;
    logic [EW:0]       w_abs;
    logic [EW-1:0]     w_mag;
    logic              w_sum_over;
    logic              w_out_free;
    logic [UW-1:0]     w_bit;
    logic [UW-1:0]     w_unit_b;
    logic              w_unit_sub;
    logic [UW-1:0]     w_unit_res;
    logic              w_unit_carry;
    logic [DIST_W-1:0] w_dist;

    // apb access
    assign pready = 1'b1;
    assign prdata = {{(PDATA_W-1){1'b0}}, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EUCLID;
        end else if (psel && penable && pwrite && pready
                     && (paddr[PADDR_W-1:2] == REG_METRIC_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    // input word decode
    assign o_in_ready   = (w_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_count_full = (r_count >= CW'(MAX_LEN));
    assign w_diff       = $signed({i_elem_a[EW-1], i_elem_a})
                          - $signed({i_elem_b[EW-1], i_elem_b});
    assign w_abs        = w_diff[EW] ? (EW+1)'(0) - w_diff : w_diff;
    assign w_mag        = w_abs[EW-1:0];

    assign w_sum_over   = |r_acc[UW-1:SUM_W];
    assign w_out_free   = !r_out_valid || i_out_ready;

    // square root trial bit 4^k
    assign w_bit = {{(UW-1){1'b0}}, 1'b1} << {r_k, 1'b0};

    // shared unit operands
    assign w_unit_sub = (w_state == S_SQRT);
    assign w_unit_b   = w_unit_sub ? (r_mcand | w_bit) : r_mcand;

    vda_addsub #(
        .W(UW)
    ) u_addsub (
        .i_a    (r_acc),
        .i_b    (w_unit_b),
        .i_sub  (w_unit_sub),
        .o_res  (w_unit_res),
        .o_carry(w_unit_carry)
    );

    // sequencer
    always_comb begin
        w_stat.accept      = w_accept;
        w_stat.count_full  = w_count_full;
        w_stat.mode_manh   = (r_item_mode == MODE_MANHATTAN);
        w_stat.last        = (w_state == S_IDLE) ? i_last_elem : r_last;
        w_stat.mplier_zero = (r_mplier == '0);
        w_stat.sum_over    = w_sum_over;
        w_stat.sat         = r_sat;
        w_stat.k_zero      = (r_k == '0);
        w_stat.out_free    = w_out_free;
    end

    vda_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_state(w_state)
    );

    // result value, clamped to the output width
    always_comb begin
        if (r_sat) begin
            w_dist = '1;
        end else if (r_item_mode == MODE_MANHATTAN) begin
            w_dist = (|r_acc[UW-1:DIST_W]) ? '1 : r_acc[DIST_W-1:0];
        end else begin
            w_dist = (|r_mcand[UW-1:DIST_W]) ? '1 : r_mcand[DIST_W-1:0];
        end
    end

    // accumulator, count and saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (w_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_count_full) begin
                            r_sat <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= w_unit_res;
                    end
                end
                S_CHK: begin
                    if (w_sum_over) begin
                        r_acc <= UW'({SUM_W{1'b1}});
                        r_sat <= 1'b1;
                    end else if (r_last && !r_sat && r_item_mode == MODE_EUCLID) begin
                        r_acc <= r_acc << (2 * FRAC_W);
                    end
                end
                S_SQRT: begin
                    if (w_unit_carry) begin
                        r_acc <= w_unit_res;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_acc   <= '0;
                        r_count <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // multiplier operands, root and step counter
    always_ff @(posedge i_clk) begin
        unique case (w_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_item_mode <= r_mode;
                    r_last      <= i_last_elem;
                    r_mcand     <= UW'(w_mag);
                    r_mplier    <= (r_mode == MODE_MANHATTAN) ? EW'(1) : w_mag;
                end
            end
            S_MUL: begin
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            S_CHK: begin
                r_mcand <= '0;
                r_k     <= SQRT_KW'(SQRT_STEPS - 1);
            end
            S_SQRT: begin
                r_mcand <= w_unit_carry ? ((r_mcand >> 1) | w_bit) : (r_mcand >> 1);
                r_k     <= r_k - SQRT_KW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_state == S_DONE && w_out_free) begin
            r_dist <= w_dist;
            r_ovf  <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;
    assign o_overflow  = r_ovf;

endmodule

// ===== tb/vda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vda_checker
// watches the input, result and register ports of the vector distance
// accumulator, predicts each distance word from the accepted element words
// and compares every accepted result word field by field, oldest first
// ----------------------------------------------------------------------------
module vda_checker
    import vda_pkg::*;
#(
    parameter int MAX_LEN    = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last_elem,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic                  i_overflow,
    // register port
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [PADDR_W-1:0]    i_paddr,
    input  logic [PDATA_W-1:0]    i_pwdata,
    // status to the testbench top
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_dist_word;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // predicted distance words, oldest first
    t_dist_word dist_expected_q[$];
    t_dist_word dist_want;

    // shadow of the block state and its register
    logic             metric;
    logic [SUM_W-1:0] sum_acc;
    int unsigned      pair_count;
    logic             sum_sat;
    int unsigned      fail_total = 0;

    // integer square root, one result bit at a time from the top
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // fold one element pair into the sum, predict a word on the last pair
    function automatic void accumulate_pair(input logic [ELEM_WIDTH-1:0] a,
                                            input logic [ELEM_WIDTH-1:0] b,
                                            input logic last);
        logic signed [ELEM_WIDTH:0] diff;
        logic [ELEM_WIDTH:0]        mag;
        logic [SUM_W-1:0]           term;
        logic [63:0]                dist_val;
        t_dist_word                 pred;
        diff = $signed({a[ELEM_WIDTH-1], a}) - $signed({b[ELEM_WIDTH-1], b});
        mag  = diff[ELEM_WIDTH] ? -diff : diff;
        term = (metric == MODE_MANHATTAN) ? SUM_W'(mag) : SUM_W'(mag) * SUM_W'(mag);

        // pairs past the length limit are dropped and mark the vector
        if (pair_count >= MAX_LEN) begin
            sum_sat = 1'b1;
        end else begin
            pair_count++;
            if (term > SUM_MAX - sum_acc) begin
                sum_acc = SUM_MAX;
                sum_sat = 1'b1;
            end else begin
                sum_acc = sum_acc + term;
            end
        end
        if (!last) begin
            return;
        end

        // final conversion uses the metric in force at the last pair
        if (sum_sat) begin
            dist_val = 64'(DIST_MAX);
        end else if (metric == MODE_MANHATTAN) begin
            dist_val = 64'(sum_acc);
        end else begin
            dist_val = floor_root(64'(sum_acc) << (2 * FRAC_W));
        end
        if (dist_val > 64'(DIST_MAX)) begin
            dist_val = 64'(DIST_MAX);
        end
        pred.distance = dist_val[DIST_W-1:0];
        pred.overflow = sum_sat;
        dist_expected_q.push_back(pred);

        sum_acc    = '0;
        pair_count = 0;
        sum_sat    = 1'b0;
    endfunction

    // sample all ports at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            metric     = MODE_EUCLID;
            sum_acc    = '0;
            pair_count = 0;
            sum_sat    = 1'b0;
            dist_expected_q.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[PADDR_W-1:2] == REG_METRIC_MODE) begin
                metric = i_pwdata[0];
            end

            // result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (dist_expected_q.size() == 0) begin
                    $error("unexpected result word: distance %0d overflow %0d",
                           i_distance, i_overflow);
                    fail_total++;
                end else begin
                    dist_want = dist_expected_q.pop_front();
                    if (i_distance !== dist_want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               dist_want.distance, i_distance);
                        fail_total++;
                    end
                    if (i_overflow !== dist_want.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               dist_want.overflow, i_overflow);
                        fail_total++;
                    end
                end
            end

            // element word
            if (i_in_valid && i_in_ready) begin
                accumulate_pair(i_elem_a, i_elem_b, i_last_elem);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= dist_expected_q.size();
    end

endmodule

// ===== tb/vector_distance_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_accumulator_tb
// drives element words and register writes into the accumulator: directed
// extremes, mode changes between and inside vectors, then random vectors in
// both metrics with random gaps on both channels, a long result back-pressure
// stretch and gap-free stretches; the checker beside the block predicts and
// compares every word
// ----------------------------------------------------------------------------
module vector_distance_accumulator_tb;
    import vda_pkg::*;

    localparam int MAX_LEN        = 4096;
    localparam int ELEM_W         = 16;
    localparam int SETTLE_CYCLES  = 64;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_WORDS    = 100;

    localparam logic [PADDR_W-1:0] ADDR_METRIC_MODE = {REG_METRIC_MODE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_NO_REG      = {~REG_METRIC_MODE, 2'b00};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [ELEM_W-1:0]     i_elem_a    = '0;
    logic [ELEM_W-1:0]     i_elem_b    = '0;
    logic                  i_last_elem = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_overflow;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_W-1:0]    paddr       = '0;
    logic [PDATA_W-1:0]    pwdata      = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int unsigned           fail_count;
    int unsigned           pending;

    // traffic shaping
    logic                  no_idle     = 1'b0;
    logic                  hold_req    = 1'b0;
    logic                  hold_seen   = 1'b0;
    int unsigned           hold_left   = 0;
    int unsigned           quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    vector_distance_accumulator #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_last_elem (i_last_elem),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_overflow  (o_overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    vda_checker #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_W)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last_elem  (i_last_elem),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_distance   (o_distance),
        .i_overflow   (o_overflow),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** vector_distance_accumulator: FAILED **");
            $finish;
        end
    end

    // offer one element word, holding it until accepted
    task automatic send_word(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                             input logic last);
        if (!no_idle) begin
            while ($urandom_range(99) < 12) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_elem_a    <= a;
        i_elem_b    <= b;
        i_last_elem <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // stop offering, wait for all results and let the datapath go quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // select the metric once the block is idle, junk in the upper data bits
    task automatic set_metric(input logic m);
        logic [PDATA_W-1:0] data;
        data    = $urandom;
        data[0] = m;
        drain();
        write_reg(ADDR_METRIC_MODE, data);
    endtask

    // element values: extremes, small, or anything
    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return ELEM_W'($urandom_range(16)) - ELEM_W'(8);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    initial begin
        int words_left;
        int len;
        int k;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // euclidean vectors at the extremes (reset metric)
        send_word(16'h7FFF, 16'h8000, 1'b1);
        send_word(16'h8000, 16'h7FFF, 1'b1);
        send_word(16'h0000, 16'h0000, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        send_word(16'd1, 16'd0, 1'b0);
        send_word(16'd0, 16'd1, 1'b1);
        send_word(16'd1000, 16'hFC18, 1'b0);
        send_word(16'h8000, 16'h8000, 1'b0);
        send_word(16'd12345, 16'hA5A5, 1'b1);

        // write to an unmapped register leaves the metric alone
        drain();
        write_reg(ADDR_NO_REG, 32'hFFFF_FFFF);
        send_word(16'd3, 16'hFFFC, 1'b1);

        // manhattan extremes
        set_metric(MODE_MANHATTAN);
        send_word(16'h7FFF, 16'h8000, 1'b1);
        send_word(16'h8000, 16'h7FFF, 1'b1);
        send_word(16'h0000, 16'h0000, 1'b1);
        send_word(16'h5555, 16'hAAAA, 1'b0);
        send_word(16'hFFFF, 16'h0001, 1'b0);
        send_word(16'h7FFF, 16'h7FFE, 1'b1);

        // metric switched inside a vector, both directions
        send_word(16'd100, 16'd0, 1'b0);
        set_metric(MODE_EUCLID);
        send_word(16'd3, 16'd0, 1'b1);
        send_word(16'd10, 16'd0, 1'b0);
        set_metric(MODE_MANHATTAN);
        send_word(16'd5, 16'd0, 1'b1);

        // random vectors, metric alternating per phase
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            set_metric(phase[0] ? MODE_MANHATTAN : MODE_EUCLID);
            no_idle <= (phase == 3 || phase == 5);
            if (phase == 5) begin
                hold_req <= ~hold_req;
            end
            words_left = PHASE_WORDS;
            while (words_left > 0) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(6, 1);
                for (k = 0; k < len; k++) begin
                    send_word(pick_elem(), pick_elem(), k == len - 1);
                end
                words_left -= len;
            end
        end

        // wind down
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** vector_distance_accumulator: PASSED **");
        end else begin
            $display("** vector_distance_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
